@@ design/lcg_pkg.sv @@
// ----------------------------------------------------------------------------
// lcg_pkg: shared constants and types for the linear chirp generator
// Phase and sample widths, register indexes, and the quarter-wave sine
// table builder used by the lookup ROM.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int LUT_ADDR_BITS = 10;
  localparam int LUT_SIZE      = 1 << LUT_ADDR_BITS;
  localparam int ENTRY_BITS    = SAMPLE_BITS - 1;

  localparam int AMP_BITS      = 15;
  localparam int LEN_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_START_STEP     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_INCREMENT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHIRP_LENGTH   = 2'd3;

  // register reset values
  localparam logic [31:0]         START_STEP_RST     = 32'd0;
  localparam logic signed [31:0]  STEP_INCREMENT_RST = 32'sd0;
  localparam logic [AMP_BITS-1:0] AMPLITUDE_RST      = 15'd32767;
  localparam logic [LEN_BITS-1:0] CHIRP_LENGTH_RST   = 16'd1024;

  typedef logic [PHASE_BITS-1:0]    phase_t;
  typedef logic [LUT_ADDR_BITS-1:0] lut_addr_t;
  typedef logic [ENTRY_BITS-1:0]    entry_t;
  typedef entry_t                   qw_table_t [LUT_SIZE];

  // Step of sample zero: start step plus the floor of half the increment.
  function automatic phase_t chirp_start_step(input logic [31:0] start,
                                              input logic signed [31:0] inc);
    logic signed [31:0] half;
    begin
      half = inc >>> 1;
      return PHASE_BITS'(start) + PHASE_BITS'(half);
    end
  endfunction

  // Quotient of a non-negative dividend by a positive divisor, by shift and
  // subtract; used only while the table is built at elaboration.
  function automatic longint div_pos(input longint num, input longint den);
    longint rem;
    longint quo;
    begin
      rem = 0;
      quo = 0;
      for (int b = 62; b >= 0; b--) begin
        rem = (rem << 1) | ((num >>> b) & 64'sd1);
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo = quo | 64'sd1;
        end
      end
      return quo;
    end
  endfunction

  // Quarter-wave table, sampled at bin centers; sine by Taylor series in Q30.
  function automatic qw_table_t build_table();
    qw_table_t  t;
    longint     half_pi_q30;
    longint     full;
    longint     x;
    longint     x2;
    longint     term;
    longint     sum;
    longint     v;
    begin
      half_pi_q30 = 64'sh1921FB54442D1847 >>> 30;
      full        = longint'(1) << (SAMPLE_BITS - 1);
      for (int k = 0; k < LUT_SIZE; k++) begin
        x    = (half_pi_q30 * longint'(2 * k + 1)) >>> (LUT_ADDR_BITS + 1);
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 9; n++) begin
          term = div_pos((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
          if ((n & 1) != 0) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        v = (sum * full + (longint'(1) << 29)) >>> 30;
        if (v > full - 1) begin
          v = full - 1;
        end
        t[k] = ENTRY_BITS'(v);
      end
      return t;
    end
  endfunction

endpackage

@@ design/linear_chirp_generator.sv @@
// ----------------------------------------------------------------------------
// linear_chirp_generator: linear FM chirp source, complex Q1.15 output
// Each input word (one tick, with a restart flag) yields one complex sample
// amplitude * (cos, sin) of a quadratic phase, plus a last-sample flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per sample tick; in_restart = 1 begins a new chirp at
//            sample zero on that tick.
//   out_*  : sample_real/sample_imag and last_sample, one word per input word.
//   cfg_*  : register writes (start_step, step_increment, amplitude,
//            chirp_length); always ready. Write only while the block is idle.
//            Start step takes effect at the next chirp start; step increment,
//            amplitude and chirp length at once.
// Timing: two pipeline registers (table ROM read, then scale and sign) lie
//   between an accepted input word and its result. One word per cycle is
//   accepted and delivered while out_ready stays high; phase and step each
//   update by a single add per accepted word.
// Reset: registers return to their defaults, phase, step and sample count
//   clear, and the pipeline empties.
// Stall: when out_ready is low the output holds; the ROM stage still takes
//   one more word, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module linear_chirp_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lcg_pkg::SAMPLE_BITS-1:0] out_sample_real,
  output logic signed [lcg_pkg::SAMPLE_BITS-1:0] out_sample_imag,
  output logic                                out_last_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lcg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import lcg_pkg::*;

  localparam int PROD_BITS = AMP_BITS + ENTRY_BITS + 1;

  // configuration registers
  logic [31:0]         start_step_r;
  logic signed [31:0]  step_inc_r;
  logic [AMP_BITS-1:0] amplitude_r;
  logic [LEN_BITS-1:0] chirp_len_r;

  // chirp state
  phase_t              phase_r, phase_nxt;
  phase_t              step_r, step_nxt;
  logic [LEN_BITS-1:0] index_r, index_nxt;

  // pipeline control
  logic s1_valid_r;
  logic s1_last_r;
  logic [1:0] s1_quad_r;
  logic out_valid_r;
  logic advance;
  logic in_fire;

  // sample-tick logic
  phase_t              reload_step;
  phase_t              eff_phase;
  phase_t              eff_step;
  logic [LEN_BITS-1:0] eff_index;
  logic [LEN_BITS:0]   eff_len;
  logic                last_nxt;
  logic [1:0]          quad;
  lut_addr_t           lut_idx;
  lut_addr_t           sin_addr;
  lut_addr_t           cos_addr;
  entry_t              sin_entry;
  entry_t              cos_entry;

  // output stage
  logic [PROD_BITS-1:0]          sin_prod, cos_prod;
  logic [SAMPLE_BITS-1:0]        sin_mag, cos_mag;
  logic signed [SAMPLE_BITS-1:0] real_nxt, imag_nxt;
  logic signed [SAMPLE_BITS-1:0] real_r, imag_r;
  logic                          last_r;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance || !s1_valid_r;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r <= START_STEP_RST;
      step_inc_r   <= STEP_INCREMENT_RST;
      amplitude_r  <= AMPLITUDE_RST;
      chirp_len_r  <= CHIRP_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_STEP:     start_step_r <= cfg_data[31:0];
        REG_STEP_INCREMENT: step_inc_r   <= $signed(cfg_data[31:0]);
        REG_AMPLITUDE:      amplitude_r  <= cfg_data[AMP_BITS-1:0];
        REG_CHIRP_LENGTH:   chirp_len_r  <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // restart wins over the stored state; a zero length acts as one
  always_comb begin
    reload_step = chirp_start_step(start_step_r, step_inc_r);
    eff_phase   = in_restart ? '0 : phase_r;
    eff_step    = in_restart ? reload_step : step_r;
    eff_index   = in_restart ? '0 : index_r;
    eff_len     = (chirp_len_r == '0) ? (LEN_BITS+1)'(1) : {1'b0, chirp_len_r};
    last_nxt    = ({1'b0, eff_index} + (LEN_BITS+1)'(1)) >= eff_len;
    if (last_nxt) begin
      phase_nxt = '0;
      step_nxt  = reload_step;
      index_nxt = '0;
    end else begin
      phase_nxt = eff_phase + eff_step;
      step_nxt  = eff_step + PHASE_BITS'(step_inc_r);
      index_nxt = eff_index + LEN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= chirp_start_step(START_STEP_RST, STEP_INCREMENT_RST);
      index_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      index_r <= index_nxt;
    end
  end

  // odd quadrants read the mirrored index for sine
  assign quad     = eff_phase[PHASE_BITS-1 -: 2];
  assign lut_idx  = eff_phase[PHASE_BITS-3 -: LUT_ADDR_BITS];
  assign sin_addr = quad[0] ? ~lut_idx : lut_idx;
  assign cos_addr = quad[0] ? lut_idx : ~lut_idx;

  lcg_quarter_rom u_rom (
    .clk      (clk),
    .en       (in_fire),
    .addr_a   (sin_addr),
    .addr_b   (cos_addr),
    .data_a_r (sin_entry),
    .data_b_r (cos_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_quad_r <= quad;
      s1_last_r <= last_nxt;
    end
  end

  // scale with rounding, then apply the quadrant sign
  always_comb begin
    sin_prod = PROD_BITS'(amplitude_r) * PROD_BITS'(sin_entry)
             + PROD_BITS'(1 << (AMP_BITS - 1));
    cos_prod = PROD_BITS'(amplitude_r) * PROD_BITS'(cos_entry)
             + PROD_BITS'(1 << (AMP_BITS - 1));
    sin_mag  = sin_prod[PROD_BITS-1 -: SAMPLE_BITS];
    cos_mag  = cos_prod[PROD_BITS-1 -: SAMPLE_BITS];
    imag_nxt = s1_quad_r[1] ? $signed(-sin_mag) : $signed(sin_mag);
    real_nxt = (s1_quad_r[1] ^ s1_quad_r[0]) ? $signed(-cos_mag) : $signed(cos_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      real_r <= real_nxt;
      imag_r <= imag_nxt;
      last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_real = real_r;
  assign out_sample_imag = imag_r;
  assign out_last_sample = last_r;

`ifndef SYNTHESIS
  // a last sample always rewinds the chirp
  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_nxt) |=> (index_r == '0 && phase_r == '0))
    else $error("chirp state not rewound after last sample");

  // backpressure reaches the input only with both stages full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  // a stalled output with a full ROM stage keeps that stage's word
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_quad_r) && $stable(s1_last_r)))
    else $error("ROM stage word changed during stall");
`endif

endmodule

@@ design/lcg_quarter_rom.sv @@
// ----------------------------------------------------------------------------
// lcg_quarter_rom: dual-read quarter-wave sine ROM
// Two addresses read per cycle; read data registered and held when en is low.
// ----------------------------------------------------------------------------
module lcg_quarter_rom (
  input  logic              clk,
  input  logic              en,
  input  lcg_pkg::lut_addr_t addr_a,
  input  lcg_pkg::lut_addr_t addr_b,
  output lcg_pkg::entry_t    data_a_r,
  output lcg_pkg::entry_t    data_b_r
);
  import lcg_pkg::*;

  localparam qw_table_t QW = build_table();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= QW[addr_a];
      data_b_r <= QW[addr_b];
    end
  end

endmodule

@@ test/linear_chirp_generator_test.sv @@
// ----------------------------------------------------------------------------
// linear_chirp_generator_test: self-checking bench for the chirp generator
// Drives restart ticks through the valid/ready input, programs the four
// registers between phases, and compares every complex sample and last flag
// against an in-bench phase/step/table predictor. Both sides idle at random.
// ----------------------------------------------------------------------------
module linear_chirp_generator_test;
  import lcg_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 800;

  typedef enum bit [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] cos_part;
    logic signed [SAMPLE_BITS-1:0] sin_part;
    logic                          last;
  } chirp_sample_t;

  class chirp_scoreboard;
    bit [ENTRY_BITS-1:0] qwave [LUT_SIZE];
    logic [31:0]         start_step;
    logic signed [31:0]  step_inc;
    logic [AMP_BITS-1:0] amp;
    logic [LEN_BITS-1:0] len;
    phase_t              phase;
    phase_t              step;
    logic [LEN_BITS-1:0] sidx;
    chirp_sample_t       expected_samples [$];
    int                  errors;
    int                  checked;

    function new();
      build_qwave();
      start_step = START_STEP_RST;
      step_inc   = STEP_INCREMENT_RST;
      amp        = AMPLITUDE_RST;
      len        = CHIRP_LENGTH_RST;
      errors     = 0;
      checked    = 0;
      restart_chirp();
    endfunction

    // Quarter-wave sine at bin centers, Taylor series in Q30.
    function void build_qwave();
      longint hp;
      longint x;
      longint x2;
      longint term;
      longint acc;
      longint v;
      hp = 64'sh1921FB54442D1847 >>> 30;
      for (int k = 0; k < LUT_SIZE; k++) begin
        x    = (hp * longint'(2 * k + 1)) >>> (LUT_ADDR_BITS + 1);
        x2   = (x * x) >>> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 9; n++) begin
          term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
          acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0) begin
          acc = 0;
        end
        v = (acc * (longint'(1) << (SAMPLE_BITS - 1)) + (longint'(1) << 29)) >>> 30;
        qwave[k] = (v > 32767) ? 15'h7FFF : v[ENTRY_BITS-1:0];
      end
    endfunction

    function void restart_chirp();
      phase = '0;
      step  = phase_t'(start_step) + phase_t'(step_inc >>> 1);
      sidx  = '0;
    endfunction

    function logic [SAMPLE_BITS-1:0] scale(bit [ENTRY_BITS-1:0] entry, bit negate);
      int unsigned mag;
      mag = (32'(amp) * 32'(entry) + 32'd16384) >> 15;
      return negate ? SAMPLE_BITS'(0 - mag) : SAMPLE_BITS'(mag);
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_START_STEP:     start_step = data;
        REG_STEP_INCREMENT: step_inc   = data;
        REG_AMPLITUDE:      amp        = data[AMP_BITS-1:0];
        REG_CHIRP_LENGTH:   len        = data[LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit restart);
      chirp_sample_t       s;
      quadrant_t           quad;
      lut_addr_t           tix;
      bit [ENTRY_BITS-1:0] e_tab;
      bit [ENTRY_BITS-1:0] e_mir;
      bit [LEN_BITS:0]     span;
      if (restart) begin
        restart_chirp();
      end
      quad  = quadrant_t'(phase[PHASE_BITS-1 -: 2]);
      tix   = phase[PHASE_BITS-3 -: LUT_ADDR_BITS];
      e_tab = qwave[tix];
      e_mir = qwave[~tix];
      case (quad)
        QUAD_I: begin
          s.cos_part = scale(e_mir, 1'b0);
          s.sin_part = scale(e_tab, 1'b0);
        end
        QUAD_II: begin
          s.cos_part = scale(e_tab, 1'b1);
          s.sin_part = scale(e_mir, 1'b0);
        end
        QUAD_III: begin
          s.cos_part = scale(e_mir, 1'b1);
          s.sin_part = scale(e_tab, 1'b1);
        end
        default: begin
          s.cos_part = scale(e_tab, 1'b0);
          s.sin_part = scale(e_mir, 1'b1);
        end
      endcase
      // zero length behaves as one
      span   = (len == 0) ? (LEN_BITS+1)'(1) : {1'b0, len};
      s.last = ({1'b0, sidx} + (LEN_BITS+1)'(1)) >= span;
      expected_samples.push_back(s);
      if (s.last) begin
        restart_chirp();
      end else begin
        phase = phase + step;
        step  = step + phase_t'(step_inc);
        sidx  = sidx + LEN_BITS'(1);
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_BITS-1:0] re,
                               logic signed [SAMPLE_BITS-1:0] im, logic last);
      chirp_sample_t e;
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: real %0d imag %0d last %0b", $time, re, im, last);
        return;
      end
      e = expected_samples.pop_front();
      if (re !== e.cos_part) begin
        errors++;
        $display("%0t: word %0d real: expected %0d, actual %0d",
                 $time, checked, e.cos_part, re);
      end
      if (im !== e.sin_part) begin
        errors++;
        $display("%0t: word %0d imag: expected %0d, actual %0d",
                 $time, checked, e.sin_part, im);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: word %0d last: expected %0b, actual %0b", $time, checked, e.last, last);
      end
      checked++;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_restart;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] out_sample_real;
  logic signed [SAMPLE_BITS-1:0] out_sample_imag;
  logic                          out_last_sample;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;

  chirp_scoreboard sb;
  bit              tx_idle_on;
  bit              rx_idle_on;
  int              out_hold;
  int              cycles;
  int              sent;

  linear_chirp_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_real (out_sample_real),
    .out_sample_imag (out_sample_imag),
    .out_last_sample (out_last_sample),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch all three channels; draw the receiver's stall after each word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_tick(in_restart);
      end
      if (out_valid && out_ready) begin
        sb.check_sample(out_sample_real, out_sample_imag, out_last_sample);
        out_hold = rx_idle_on ? $urandom_range(0, 10) : 0;
      end else if (out_hold > 0) begin
        out_hold--;
      end
    end
    out_ready <= (out_hold == 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drive_tick(input bit restart);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Mask bit i selects register i; valid stays high across the burst.
  task automatic set_regs(input bit [3:0] mask, input logic [31:0] start,
                          input logic [31:0] inc, input logic [31:0] amp,
                          input logic [31:0] len);
    if (mask[REG_START_STEP])     write_cfg(REG_START_STEP, start);
    if (mask[REG_STEP_INCREMENT]) write_cfg(REG_STEP_INCREMENT, inc);
    if (mask[REG_AMPLITUDE])      write_cfg(REG_AMPLITUDE, amp);
    if (mask[REG_CHIRP_LENGTH])   write_cfg(REG_CHIRP_LENGTH, len);
    if (mask != 0) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // Hold the input low until every sample is back, then let the pipe settle.
  // Step past the current edge first so the word accepted at it is already noted.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 1 << 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_inc();
    case ($urandom_range(0, 6))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3, 4:    return 32'($urandom_range(0, 2_000_000)) - 32'd1_000_000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'd32767;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd65535;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  initial begin
    int n;
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_START_STEP;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    out_hold   = 0;
    cycles     = 0;
    sent       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, restart mid-chirp
    drive_tick(1'b0);
    drive_tick(1'b1);
    drive_tick(1'b0);
    drain(4);

    // quarter turn per sample walks all quadrants; short chirp wraps
    set_regs(4'b1111, 32'h4000_0000, 32'd0, 32'd32767, 32'd5);
    drive_tick(1'b1);
    repeat (5) drive_tick(1'b0);
    drain(4);

    // zero length: every word is last; most negative increment, zero amplitude
    set_regs(4'b1111, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
    repeat (3) drive_tick(1'b0);
    drain(4);

    // largest increment and length, smallest nonzero amplitude, phase wrap
    set_regs(4'b1111, 32'h1234_5678, 32'h7FFF_FFFF, 32'd1, 32'd65535);
    repeat (3) drive_tick(1'b0);
    drive_tick(1'b1);
    drain(4);

    // odd negative increment
    set_regs(4'b1111, 32'h0100_0000, 32'hFFFF_FFFD, 32'd12345, 32'd3);
    drive_tick(1'b1);
    repeat (3) drive_tick(1'b0);
    drain(4);

    // odd positive increment, then shorten the chirp below the current count
    set_regs(4'b1010, 32'd0, 32'd3, 32'd0, 32'd1000);
    drive_tick(1'b1);
    repeat (4) drive_tick(1'b0);
    drain(4);
    set_regs(4'b1000, 32'd0, 32'd0, 32'd0, 32'd2);
    repeat (2) drive_tick(1'b0);
    drain(4);

    while (sent < RANDOM_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      set_regs(4'($urandom_range(0, 15)), pick_start(), pick_inc(), pick_amp(),
               pick_len());
      n = $urandom_range(30, 120);
      repeat (n) begin
        drive_tick($urandom_range(0, 15) == 0);
        sent++;
      end
      drain(4);
    end

    drain(10);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
